// File: design/hdc_pkg.sv
package hdc_pkg;

  localparam int unsigned MAX_RUNGS = 4;
  localparam int unsigned RUNG_REGS = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned RUNG_W    = TIME_W + ACT_W;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned IDX_W     = $clog2(RUNG_REGS);

  // rungs in use never exceed either bound
  localparam int unsigned RUNG_LIMIT = (MAX_RUNGS < RUNG_REGS) ? MAX_RUNGS : RUNG_REGS;

  typedef enum logic [ADDR_W-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_COUNT    = 3'd1,
    REG_RUNG0    = 3'd2,
    REG_RUNG1    = 3'd3,
    REG_RUNG2    = 3'd4,
    REG_RUNG3    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [TIME_W-1:0] thr;
  } rung_t;

  // snapshot of one sample after the press/release state update
  typedef struct packed {
    logic              down;
    logic              fire;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] rel_held;
  } track_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

// File: design/hdc_if.sv
interface hdc_in_if import hdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pressed;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, pressed, now_ms, input ready);
  modport sink (input valid, pressed, now_ms, output ready);
endinterface

interface hdc_out_if import hdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  release_action;
  logic [TIME_W-1:0] held_time;
  logic [ACT_W-1:0]  pending_action;
  logic [TIME_W-1:0] ms_to_next;
  logic [ACT_W-1:0]  upcoming_action;
  logic [TIME_W-1:0] current_rung_start;
  logic [TIME_W-1:0] next_rung_start;

  modport source (output valid, release_action, held_time, pending_action, ms_to_next,
                  upcoming_action, current_rung_start, next_rung_start, input ready);
  modport sink (input valid, release_action, held_time, pending_action, ms_to_next,
                upcoming_action, current_rung_start, next_rung_start, output ready);
endinterface

interface hdc_cfg_if import hdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [RUNG_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: design/hold_duration_classifier.sv
// An accepted sample is held by the press tracker, then by the output register.
// Throughput: one sample per cycle; the press tracker and the output register each
// take a new transaction every cycle while the result side keeps up.
// Reset (rst, synchronous, active high): button released, press start and all
// configuration registers cleared, both pipeline stages empty.
module hold_duration_classifier import hdc_pkg::*; (
  input logic      clk,
  input logic      rst,
  hdc_cfg_if.sink  cfg,
  hdc_in_if.sink   sample,
  hdc_out_if.source result
);

  // configuration
  logic [TIME_W-1:0] debounce_ms;
  logic [CNT_W-1:0]  rung_count;
  rung_t             rungs [RUNG_REGS];
  logic [CNT_W-1:0]  n;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= '0;
      rung_count  <= '0;
      for (int i = 0; i < RUNG_REGS; i++) begin
        rungs[i] <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_DEBOUNCE: debounce_ms <= cfg.data[TIME_W-1:0];
        REG_COUNT:    rung_count  <= cfg.data[CNT_W-1:0];
        REG_RUNG0:    rungs[0]    <= {cfg.data[RUNG_W-1:TIME_W], cfg.data[TIME_W-1:0]};
        REG_RUNG1:    rungs[1]    <= {cfg.data[RUNG_W-1:TIME_W], cfg.data[TIME_W-1:0]};
        REG_RUNG2:    rungs[2]    <= {cfg.data[RUNG_W-1:TIME_W], cfg.data[TIME_W-1:0]};
        REG_RUNG3:    rungs[3]    <= {cfg.data[RUNG_W-1:TIME_W], cfg.data[TIME_W-1:0]};
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // clamp the rung count to the rungs that exist
  assign n = (rung_count > CNT_W'(RUNG_LIMIT)) ? CNT_W'(RUNG_LIMIT) : rung_count;

  // handshake: stage 1 advances when the output register is free or being drained
  logic   s1_valid;
  logic   adv;
  logic   load;
  logic   out_valid;
  track_t snap;

  assign adv          = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || adv;
  assign load         = sample.valid && sample.ready;
  assign result.valid = out_valid;

  // stage 1: press/release tracking and held time
  hdc_track u_track (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .adv     (adv),
    .pressed (sample.pressed),
    .now_ms  (sample.now_ms),
    .valid   (s1_valid),
    .snap    (snap)
  );

  // stage 2: rung picks for the release time and for the live held time
  pick_t rel_pick;
  pick_t live_pick;

  hdc_sel u_sel_rel (
    .held        (snap.rel_held),
    .debounce_ms (debounce_ms),
    .n           (n),
    .rungs       (rungs),
    .pick        (rel_pick)
  );

  hdc_sel u_sel_live (
    .held        (snap.held),
    .debounce_ms (debounce_ms),
    .n           (n),
    .rungs       (rungs),
    .pick        (live_pick)
  );

  // first rung in use not yet reached, lowest index wins
  logic             up_hit;
  logic [IDX_W-1:0] up_idx;

  always_comb begin
    up_hit = 1'b0;
    up_idx = '0;
    for (int i = RUNG_REGS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < n && snap.held < rungs[i].thr) begin
        up_hit = 1'b1;
        up_idx = IDX_W'(i);
      end
    end
  end

  logic [ACT_W-1:0]  rel_act_next;
  logic [ACT_W-1:0]  pend_next;
  logic [TIME_W-1:0] to_next_next;
  logic [ACT_W-1:0]  upc_next;
  logic [TIME_W-1:0] cur_next;
  logic [TIME_W-1:0] nxt_next;
  logic [CNT_W-1:0]  after_idx;
  logic [IDX_W-1:0]  follow_idx;

  assign after_idx  = CNT_W'(live_pick.idx) + CNT_W'(1);
  assign follow_idx = after_idx[IDX_W-1:0];

  always_comb begin
    rel_act_next = (snap.fire && rel_pick.hit) ? rungs[rel_pick.idx].act : '0;
    pend_next    = (snap.down && live_pick.hit) ? rungs[live_pick.idx].act : '0;
    to_next_next = (snap.down && up_hit) ? rungs[up_idx].thr - snap.held : '0;
    upc_next     = (snap.down && up_hit) ? rungs[up_idx].act : '0;
    if (live_pick.hit) begin
      cur_next = rungs[live_pick.idx].thr;
      // the last rung in use repeats its own threshold
      nxt_next = (after_idx >= n) ? rungs[live_pick.idx].thr : rungs[follow_idx].thr;
    end else begin
      cur_next = '0;
      nxt_next = (n != '0) ? rungs[0].thr : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.release_action     <= rel_act_next;
      result.held_time          <= snap.held;
      result.pending_action     <= pend_next;
      result.ms_to_next         <= to_next_next;
      result.upcoming_action    <= upc_next;
      result.current_rung_start <= cur_next;
      result.next_rung_start    <= nxt_next;
    end
  end

endmodule

// File: design/hdc_track.sv
module hdc_track import hdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              adv,
  input  logic              pressed,
  input  logic [TIME_W-1:0] now_ms,
  output logic              valid,
  output track_t            snap
);

  logic              is_down;
  logic [TIME_W-1:0] press_start;
  logic              press_edge;
  logic              release_edge;
  logic [TIME_W-1:0] since_press;

  assign press_edge   = pressed && !is_down;
  assign release_edge = !pressed && is_down;
  assign since_press  = now_ms - press_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_down     <= 1'b0;
      press_start <= '0;
      valid       <= 1'b0;
    end else begin
      if (load) begin
        valid <= 1'b1;
      end else if (adv) begin
        valid <= 1'b0;
      end
      if (load && press_edge) begin
        is_down     <= 1'b1;
        press_start <= now_ms;
      end else if (load && release_edge) begin
        is_down <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (load) begin
      snap.down     <= pressed;
      snap.fire     <= release_edge;
      snap.rel_held <= since_press;
      // a fresh press has held time zero
      snap.held     <= (pressed && !press_edge) ? since_press : '0;
    end
  end

endmodule

// File: design/hdc_sel.sv
module hdc_sel import hdc_pkg::*; (
  input  logic              [TIME_W-1:0] held,
  input  logic              [TIME_W-1:0] debounce_ms,
  input  logic              [CNT_W-1:0]  n,
  input  rung_t                          rungs [RUNG_REGS],
  output pick_t                          pick
);

  // highest rung in use whose threshold is reached wins
  always_comb begin
    pick = '0;
    if (held >= debounce_ms) begin
      for (int i = 0; i < RUNG_REGS; i++) begin
        if (CNT_W'(i) < n && held >= rungs[i].thr) begin
          pick.hit = 1'b1;
          pick.idx = IDX_W'(i);
        end
      end
    end
  end

endmodule

// File: bench/hdc_progress_check.sv
module hdc_progress_check import hdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hdc_cfg_if          cfg,
  hdc_in_if           sample,
  hdc_out_if          result,
  output int unsigned mismatches,
  output int unsigned waiting,
  output int unsigned checked,
  output int unsigned fired
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ACT_W-1:0]  release_action;
    logic [TIME_W-1:0] held_time;
    logic [ACT_W-1:0]  pending_action;
    logic [TIME_W-1:0] ms_to_next;
    logic [ACT_W-1:0]  upcoming_action;
    logic [TIME_W-1:0] current_rung_start;
    logic [TIME_W-1:0] next_rung_start;
  } progress_t;

  // shadow of the block's registers and press tracker
  logic [TIME_W-1:0] debounce;
  logic [CNT_W-1:0]  count;
  rung_t             rung [RUNG_REGS];
  logic              is_down;
  logic [TIME_W-1:0] press_start;

  progress_t   expected_progress [$];
  progress_t   due;
  progress_t   seen;
  int unsigned n_bad;
  int unsigned n_checked;
  int unsigned n_fired;

  function automatic int unsigned rungs_active();
    int unsigned n;
    n = count;
    if (n > RUNG_LIMIT) n = RUNG_LIMIT;
    return n;
  endfunction

  // highest rung in use whose threshold the held time reached; n means none
  function automatic int unsigned pick_rung(logic [TIME_W-1:0] held, int unsigned n);
    if (held < debounce || n == 0) return n;
    for (int i = int'(n) - 1; i >= 0; i--) begin
      if (held >= rung[i].thr) return i;
    end
    return n;
  endfunction

  // advance the press tracker by one sample and return the progress it reports
  function automatic progress_t classify_sample(logic pressed, logic [TIME_W-1:0] now);
    progress_t   p;
    int unsigned n;
    int unsigned sel;
    logic [TIME_W-1:0] held;
    p    = '0;
    held = '0;
    n    = rungs_active();
    if (pressed && !is_down) begin
      is_down     = 1'b1;
      press_start = now;
    end else if (!pressed && is_down) begin
      is_down = 1'b0;
      sel = pick_rung(now - press_start, n);
      if (sel < n) p.release_action = rung[sel].act;
    end
    if (is_down) held = now - press_start;
    sel = pick_rung(held, n);
    p.held_time = held;
    if (is_down) begin
      if (sel < n) p.pending_action = rung[sel].act;
      for (int i = 0; i < int'(n); i++) begin
        if (held < rung[i].thr) begin
          p.ms_to_next      = rung[i].thr - held;
          p.upcoming_action = rung[i].act;
          break;
        end
      end
    end
    if (sel < n) begin
      p.current_rung_start = rung[sel].thr;
      if (sel + 1 >= n) p.next_rung_start = rung[sel].thr;
      else p.next_rung_start = rung[sel + 1].thr;
    end else if (n > 0) begin
      p.next_rung_start = rung[0].thr;
    end
    return p;
  endfunction

  task automatic compare_field(string what, logic [TIME_W-1:0] want,
                               logic [TIME_W-1:0] got);
    if (want !== got) begin
      if (n_bad < 10)
        $display("hdc check: result %0d %s expected 0x%0h, got 0x%0h",
                 n_checked, what, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      debounce    = '0;
      count       = '0;
      foreach (rung[i]) rung[i] = '0;
      is_down     = 1'b0;
      press_start = '0;
      expected_progress.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_DEBOUNCE: debounce = cfg.data[TIME_W-1:0];
          REG_COUNT:    count    = cfg.data[CNT_W-1:0];
          REG_RUNG0:    rung[0]  = rung_t'(cfg.data);
          REG_RUNG1:    rung[1]  = rung_t'(cfg.data);
          REG_RUNG2:    rung[2]  = rung_t'(cfg.data);
          REG_RUNG3:    rung[3]  = rung_t'(cfg.data);
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_progress.size() == 0) begin
          if (n_bad < 10) $display("hdc check: result with no sample outstanding");
          n_bad++;
        end else begin
          due  = expected_progress.pop_front();
          seen = '{result.release_action, result.held_time, result.pending_action,
                   result.ms_to_next, result.upcoming_action,
                   result.current_rung_start, result.next_rung_start};
          compare_field("release_action", due.release_action, seen.release_action);
          compare_field("held_time", due.held_time, seen.held_time);
          compare_field("pending_action", due.pending_action, seen.pending_action);
          compare_field("ms_to_next", due.ms_to_next, seen.ms_to_next);
          compare_field("upcoming_action", due.upcoming_action, seen.upcoming_action);
          compare_field("current_rung_start", due.current_rung_start,
                        seen.current_rung_start);
          compare_field("next_rung_start", due.next_rung_start, seen.next_rung_start);
          n_checked++;
        end
      end
      if (sample.valid && sample.ready) begin
        due = classify_sample(sample.pressed, sample.now_ms);
        if (due.release_action != '0) n_fired++;
        expected_progress.push_back(due);
      end
    end
    mismatches <= n_bad;
    waiting    <= expected_progress.size();
    checked    <= n_checked;
    fired      <= n_fired;
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hdc_pkg::*;

  // register indexes past the last rung; writes there must change nothing
  localparam logic [ADDR_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [ADDR_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned LATENCY       = 2;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 144;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hdc_cfg_if cfg ();
  hdc_in_if  sample ();
  hdc_out_if result ();

  int unsigned mismatch_total;
  int unsigned waiting;
  int unsigned checked;
  int unsigned fired;

  // stimulus bookkeeping: what was programmed, how much was sent
  logic [TIME_W-1:0] set_debounce;
  rung_t             set_rung [RUNG_REGS];
  int unsigned       sent;
  int unsigned       writes;
  int unsigned       settings;
  int unsigned       cycles;
  logic              quiet;

  hold_duration_classifier i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .result (result)
  );

  hdc_progress_check i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample     (sample),
    .result     (result),
    .mismatches (mismatch_total),
    .waiting    (waiting),
    .checked    (checked),
    .fired      (fired)
  );

  always #6 clk = ~clk;

  // Bound the run; a hung handshake lands here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles, waiting);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: stall now and then in random bursts, never once the run goes quiet.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        result.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // One register transaction; drop valid afterwards so back-to-back writes never
  // raise and lower it in the same step.
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [RUNG_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.addr  <= addr;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    writes++;
    @(posedge clk);
  endtask

  // Program a full setting and keep a copy for aiming the hold times.
  task automatic program_regs(logic [TIME_W-1:0] deb, logic [CNT_W-1:0] cnt,
                              rung_t r0, rung_t r1, rung_t r2, rung_t r3);
    set_debounce = deb;
    set_rung[0]  = r0;
    set_rung[1]  = r1;
    set_rung[2]  = r2;
    set_rung[3]  = r3;
    write_reg(REG_DEBOUNCE, RUNG_W'(deb));
    write_reg(REG_COUNT, RUNG_W'(cnt));
    write_reg(REG_RUNG0, r0);
    write_reg(REG_RUNG1, r1);
    write_reg(REG_RUNG2, r2);
    write_reg(REG_RUNG3, r3);
    settings++;
  endtask

  // One sample transaction. Leave valid high on return so the next call can
  // follow in the same cycle; an idle burst drops it first.
  task automatic send_sample(logic pressed, logic [TIME_W-1:0] now);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid   <= 1'b1;
    sample.pressed <= pressed;
    sample.now_ms  <= now;
    do @(posedge clk); while (!sample.ready);
    sent++;
  endtask

  // Drop valid, wait for every outstanding result, then give the pipe its latency.
  task automatic settle();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Hold time aimed at the interesting points: around a threshold or the
  // debounce limit, or anywhere in range.
  function automatic logic [TIME_W-1:0] pick_held();
    logic [TIME_W-1:0] nudge;
    nudge = TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
    case ($urandom_range(0, 6))
      0:       return $urandom();
      1:       return $urandom_range(0, 3000);
      2, 3, 4: return set_rung[$urandom_range(0, RUNG_REGS - 1)].thr + nudge;
      5:       return set_debounce + nudge;
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Random setting: mostly small ladders, sorted half of the time so actions fire,
  // sometimes full-range thresholds, and odd counts.
  task automatic random_setting();
    logic [TIME_W-1:0] deb;
    logic [TIME_W-1:0] thr [RUNG_REGS];
    logic [TIME_W-1:0] swap;
    rung_t             r [RUNG_REGS];
    logic              wide;
    wide = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0:       deb = '0;
      1, 2, 3: deb = $urandom_range(0, 200);
      4:       deb = $urandom();
      default: deb = '1;
    endcase
    foreach (thr[i]) thr[i] = wide ? $urandom() : $urandom_range(0, 5000);
    if ($urandom_range(0, 1) == 0) begin
      for (int i = 0; i < RUNG_REGS; i++) begin
        for (int j = 0; j < RUNG_REGS - 1 - i; j++) begin
          if (thr[j] > thr[j + 1]) begin
            swap       = thr[j];
            thr[j]     = thr[j + 1];
            thr[j + 1] = swap;
          end
        end
      end
    end
    foreach (r[i]) r[i] = '{act: ACT_W'($urandom_range(0, 7)), thr: thr[i]};
    program_regs(deb, CNT_W'($urandom_range(0, 7)), r[0], r[1], r[2], r[3]);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                {ACT_W'($urandom_range(0, 7)), TIME_W'($urandom())});
  endtask

  // Press/hold/release sessions with random content, mixed with noise samples.
  task automatic run_sessions(int unsigned items);
    int unsigned       start;
    logic [TIME_W-1:0] t0;
    start = sent;
    while (sent - start < items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_sample(1'($urandom_range(0, 1)), $urandom());
      end else begin
        // press near the counter wrap now and then
        if ($urandom_range(0, 3) == 0) t0 = '1 - TIME_W'($urandom_range(0, 5000));
        else t0 = $urandom();
        send_sample(1'b1, t0);
        repeat ($urandom_range(0, 3)) send_sample(1'b1, t0 + pick_held());
        send_sample(1'b0, t0 + pick_held());
        repeat ($urandom_range(0, 2)) send_sample(1'b0, $urandom());
      end
    end
  endtask

  initial begin
    cfg.valid      <= 1'b0;
    cfg.addr       <= REG_DEBOUNCE;
    cfg.data       <= '0;
    sample.valid   <= 1'b0;
    sample.pressed <= 1'b0;
    sample.now_ms  <= '0;
    quiet          = 1'b0;
    set_debounce   = '0;
    foreach (set_rung[i]) set_rung[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: no rungs in use, so nothing fires; repeat both levels.
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd150);
    send_sample(1'b0, 32'd300);
    send_sample(1'b0, 32'd400);
    settle();

    // Sorted three-rung ladder with a debounce; the fourth rung lies beyond the
    // count. Hit thresholds exactly and one short, release under the debounce.
    program_regs(32'd20, 3'd3, '{3'd1, 32'd100}, '{3'd2, 32'd500},
                 '{3'd3, 32'd2000}, '{3'd7, 32'd50});
    write_reg(REG_UNMAPPED_LO, '1);
    write_reg(REG_UNMAPPED_HI, 35'h5_1234_5678);
    send_sample(1'b1, 32'd1000);
    send_sample(1'b1, 32'd1099);
    send_sample(1'b1, 32'd1100);
    send_sample(1'b0, 32'd1019);
    send_sample(1'b1, 32'd2000);
    send_sample(1'b0, 32'd2020);
    send_sample(1'b1, 32'd3000);
    send_sample(1'b0, 32'd3500);
    send_sample(1'b1, 32'd5000);
    send_sample(1'b1, 32'd7000);
    send_sample(1'b0, 32'd7001);
    settle();

    // Count above the rung limit, unsorted thresholds including zero and the
    // maximum, action codes six and seven, no debounce: released samples still
    // report a zero-threshold rung, and held time wraps across the counter.
    program_regs('0, 3'd7, '{3'd6, 32'd3000}, '{3'd1, 32'd10},
                 '{3'd7, 32'd0}, '{3'd5, '1});
    send_sample(1'b0, 32'd5);
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b0, 32'h0000_0010);
    send_sample(1'b1, '0);
    send_sample(1'b0, '1);
    settle();

    // Maximum debounce: only the longest possible hold may fire.
    program_regs('1, 3'd1, '{3'd4, 32'd0}, '0, '0, '0);
    send_sample(1'b1, '0);
    send_sample(1'b0, 32'hFFFF_FFFE);
    send_sample(1'b1, 32'd10);
    send_sample(1'b0, 32'd9);
    settle();

    // Random settings; the last phase runs with no idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
      run_sessions(PHASE_ITEMS);
      settle();
    end

    $display("tb: %0d samples under %0d settings, %0d register writes",
             sent, settings, writes);
    $display("tb: %0d results compared, %0d releases fired an action", checked, fired);
    if (mismatch_total == 0 && waiting == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/hdc_pkg.sv
design/hdc_if.sv
design/hdc_track.sv
design/hdc_sel.sv
design/hold_duration_classifier.sv
bench/hdc_progress_check.sv
bench/tb.sv
